// File: rtl/ws2i_pkg.sv
`default_nettype none

package ws2i_pkg;

    // chunk tags as they appear little-endian in a 32-bit shift register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [7:0]  PCM_OFFSET  = 8'h80;
    localparam logic [15:0] PCM_FORMAT  = 16'd1;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HEADER,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DRAIN
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK              = 4'd0,
        ST_BAD_HEADER      = 4'd1,
        ST_BAD_FMT         = 4'd2,
        ST_MISSING_CHUNK   = 4'd3,
        ST_FORMAT          = 4'd4,
        ST_LAYOUT          = 4'd5,
        ST_SHORT_DATA      = 4'd6,
        ST_NO_FRAMES       = 4'd7,
        ST_DATA_BEFORE_FMT = 4'd8
    } status_t;

    typedef struct packed {
        logic               frame_valid;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               done_res;
        status_t            status;
        logic [31:0]        sample_rate;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/ws2i_if.sv
`default_nettype none

interface ws2i_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface ws2i_frame_if;
    logic               valid;
    logic               ready;
    logic               frame_valid;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               done_res;
    logic [3:0]         status;
    logic [31:0]        sample_rate;

    modport source (output valid, output frame_valid, output left_sample,
                    output right_sample, output done_res, output status,
                    output sample_rate, input ready);
    modport sink   (input valid, input frame_valid, input left_sample,
                    input right_sample, input done_res, input status,
                    input sample_rate, output ready);
endinterface

`default_nettype wire

// File: rtl/ws2i_parser.sv
`default_nettype none

module ws2i_parser
    import ws2i_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] file_byte,
    input  wire logic       end_of_file,
    output result_t         result,
    output logic            emit
);

    phase_t      phase_reg, phase_adv, phase_next;
    logic [31:0] count_reg, count_adv, count_next;
    logic [31:0] tag_reg, tag_adv, tag_next;
    logic [31:0] len_reg, len_adv, len_next;
    logic [15:0] format_reg, format_adv, format_next;
    logic [15:0] chans_reg, chans_adv, chans_next;
    logic [31:0] rate_reg, rate_adv, rate_next;
    logic [15:0] align_reg, align_adv, align_next;
    logic [15:0] bits_reg, bits_adv, bits_next;
    logic        fmt_seen_reg, fmt_seen_adv, fmt_seen_next;
    logic [31:0] asm_reg, asm_adv, asm_next;
    logic [1:0]  idx_reg, idx_adv, idx_next;
    logic [32:0] used_reg, used_adv, used_next;

    logic [31:0] tag_shift, len_shift, asm_new;
    logic [32:0] padded, p_inc, used_sum;
    logic        last_sec, riff_bad, data_in, frame_done, frame_fits;
    logic        stereo, wide, idle, done, restart;
    status_t     data_check, status;
    logic signed [15:0] left_s, right_s;
    logic        fv;

    assign tag_shift = {file_byte, tag_reg[31:8]};
    assign len_shift = {file_byte, len_reg[31:8]};
    assign padded    = {1'b0, len_reg} + {32'd0, len_reg[0]};
    assign p_inc     = {1'b0, count_reg} + 33'd1;
    assign last_sec  = (p_inc == padded);
    assign riff_bad  = ((count_reg == 32'd3) && (tag_shift != TAG_RIFF)) ||
                       ((count_reg == 32'd11) && (tag_shift != TAG_WAVE));
    assign stereo    = (chans_reg == 16'd2);
    assign wide      = (bits_reg == 16'd16);
    assign data_in   = (count_reg < len_reg);
    assign used_sum  = used_reg + {17'd0, align_reg};
    assign frame_fits = (used_sum <= {1'b0, len_reg});
    assign idle      = (phase_reg != PH_RIFF) && (phase_reg != PH_HEADER) &&
                       (phase_reg != PH_FMT) && (phase_reg != PH_SKIP) &&
                       (phase_reg != PH_DATA);

    // frame is 1, 2 or 4 bytes
    always_comb
    begin
        if (wide && stereo)
            frame_done = (idx_reg == 2'd3);
        else if (wide || stereo)
            frame_done = (idx_reg != 2'd0);
        else
            frame_done = 1'b1;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            asm_new[8*i +: 8] = (idx_reg == 2'(i)) ? file_byte : asm_reg[8*i +: 8];
        end
    end

    // checks at the data chunk header, in priority order
    always_comb
    begin
        priority if (!fmt_seen_reg)
            data_check = ST_DATA_BEFORE_FMT;
        else if (format_reg != PCM_FORMAT)
            data_check = ST_FORMAT;
        else if ((chans_reg != 16'd1 && chans_reg != 16'd2) ||
                 (bits_reg != 16'd8 && bits_reg != 16'd16) ||
                 align_reg == 16'd0 || rate_reg == 32'd0)
            data_check = ST_LAYOUT;
        else if (len_shift < {16'd0, align_reg})
            data_check = ST_NO_FRAMES;
        else
            data_check = ST_OK;
    end

    // next state: normal progress of the parse
    always_comb
    begin
        phase_adv    = phase_reg;
        count_adv    = count_reg;
        tag_adv      = tag_reg;
        len_adv      = len_reg;
        format_adv   = format_reg;
        chans_adv    = chans_reg;
        rate_adv     = rate_reg;
        align_adv    = align_reg;
        bits_adv     = bits_reg;
        fmt_seen_adv = fmt_seen_reg;
        asm_adv      = asm_reg;
        idx_adv      = idx_reg;
        used_adv     = used_reg;
        unique case (phase_reg)
            PH_RIFF:
            begin
                tag_adv = tag_shift;
                if (count_reg == 32'd11 && !riff_bad)
                begin
                    phase_adv = PH_HEADER;
                    count_adv = 32'd0;
                end
                else
                    count_adv = p_inc[31:0];
            end
            PH_HEADER:
            begin
                if (count_reg < 32'd4)
                    tag_adv = tag_shift;
                else
                    len_adv = len_shift;
                count_adv = p_inc[31:0];
                if (count_reg == 32'd7)
                begin
                    count_adv = 32'd0;
                    if (tag_reg == TAG_FMT)
                    begin
                        if (len_shift >= FMT_MIN_LEN)
                            phase_adv = PH_FMT;
                    end
                    else if (tag_reg == TAG_DATA)
                    begin
                        if (data_check == ST_OK)
                        begin
                            phase_adv = PH_DATA;
                            asm_adv   = 32'd0;
                            idx_adv   = 2'd0;
                            used_adv  = 33'd0;
                        end
                    end
                    else if (len_shift != 32'd0)
                        phase_adv = PH_SKIP;
                end
            end
            PH_FMT, PH_SKIP:
            begin
                if (phase_reg == PH_FMT)
                begin
                    priority if (count_reg < 32'd2)
                        format_adv = {file_byte, format_reg[15:8]};
                    else if (count_reg < 32'd4)
                        chans_adv = {file_byte, chans_reg[15:8]};
                    else if (count_reg < 32'd8)
                        rate_adv = {file_byte, rate_reg[31:8]};
                    else if (count_reg >= 32'd12 && count_reg < 32'd14)
                        align_adv = {file_byte, align_reg[15:8]};
                    else if (count_reg >= 32'd14 && count_reg < 32'd16)
                        bits_adv = {file_byte, bits_reg[15:8]};
                    else
                        format_adv = format_reg;
                end
                if (last_sec)
                begin
                    if (phase_reg == PH_FMT)
                        fmt_seen_adv = 1'b1;
                    phase_adv = PH_HEADER;
                    count_adv = 32'd0;
                end
                else
                    count_adv = p_inc[31:0];
            end
            PH_DATA:
            begin
                if (data_in)
                begin
                    asm_adv = asm_new;
                    if (frame_done)
                    begin
                        idx_adv = 2'd0;
                        if (frame_fits)
                            used_adv = used_sum;
                    end
                    else
                        idx_adv = idx_reg + 2'd1;
                end
                if (!last_sec)
                    count_adv = p_inc[31:0];
            end
            default:
            begin
                phase_adv = phase_reg;
            end
        endcase
    end

    // outputs of the step
    always_comb
    begin
        fv      = 1'b0;
        done    = 1'b0;
        status  = ST_OK;
        left_s  = 16'sd0;
        right_s = 16'sd0;
        unique case (phase_reg)
            PH_RIFF:
            begin
                done   = riff_bad;
                status = ST_BAD_HEADER;
            end
            PH_HEADER:
            begin
                if (count_reg == 32'd7)
                begin
                    if (tag_reg == TAG_FMT && len_shift < FMT_MIN_LEN)
                    begin
                        done   = 1'b1;
                        status = ST_BAD_FMT;
                    end
                    else if (tag_reg == TAG_DATA && data_check != ST_OK)
                    begin
                        done   = 1'b1;
                        status = data_check;
                    end
                end
            end
            PH_DATA:
            begin
                fv   = data_in && frame_done && frame_fits;
                done = last_sec;
                if (wide)
                begin
                    left_s  = asm_new[15:0];
                    right_s = stereo ? asm_new[31:16] : asm_new[15:0];
                end
                else
                begin
                    left_s  = {asm_new[7:0] ^ PCM_OFFSET, 8'h00};
                    right_s = stereo ? {asm_new[15:8] ^ PCM_OFFSET, 8'h00} : left_s;
                end
                if (!fv)
                begin
                    left_s  = 16'sd0;
                    right_s = 16'sd0;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        // end of file before the parse finished
        if (!done && end_of_file && !idle)
        begin
            done = 1'b1;
            unique case (phase_adv)
                PH_RIFF: status = ST_BAD_HEADER;
                PH_FMT:  status = (count_adv < FMT_MIN_LEN) ? ST_BAD_FMT : ST_MISSING_CHUNK;
                PH_DATA: status = (count_adv < len_adv) ? ST_SHORT_DATA : ST_OK;
                default: status = ST_MISSING_CHUNK;
            endcase
        end
    end

    assign restart = end_of_file && (done || idle);
    assign emit    = fv || done;

    always_comb
    begin
        result.frame_valid  = fv;
        result.left_sample  = left_s;
        result.right_sample = right_s;
        result.done_res     = done;
        result.status       = done ? status : ST_OK;
        result.sample_rate  = (done && status == ST_OK) ? rate_adv : 32'd0;
    end

    always_comb
    begin
        phase_next    = phase_adv;
        count_next    = count_adv;
        tag_next      = tag_adv;
        len_next      = len_adv;
        format_next   = format_adv;
        chans_next    = chans_adv;
        rate_next     = rate_adv;
        align_next    = align_adv;
        bits_next     = bits_adv;
        fmt_seen_next = fmt_seen_adv;
        asm_next      = asm_adv;
        idx_next      = idx_adv;
        used_next     = used_adv;
        if (restart)
        begin
            phase_next    = PH_RIFF;
            count_next    = 32'd0;
            tag_next      = 32'd0;
            len_next      = 32'd0;
            format_next   = 16'd0;
            chans_next    = 16'd0;
            rate_next     = 32'd0;
            align_next    = 16'd0;
            bits_next     = 16'd0;
            fmt_seen_next = 1'b0;
            asm_next      = 32'd0;
            idx_next      = 2'd0;
            used_next     = 33'd0;
        end
        else if (done)
            phase_next = PH_DRAIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            count_reg    <= 32'd0;
            tag_reg      <= 32'd0;
            len_reg      <= 32'd0;
            format_reg   <= 16'd0;
            chans_reg    <= 16'd0;
            rate_reg     <= 32'd0;
            align_reg    <= 16'd0;
            bits_reg     <= 16'd0;
            fmt_seen_reg <= 1'b0;
            asm_reg      <= 32'd0;
            idx_reg      <= 2'd0;
            used_reg     <= 33'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            format_reg   <= format_next;
            chans_reg    <= chans_next;
            rate_reg     <= rate_next;
            align_reg    <= align_next;
            bits_reg     <= bits_next;
            fmt_seen_reg <= fmt_seen_next;
            asm_reg      <= asm_next;
            idx_reg      <= idx_next;
            used_reg     <= used_next;
        end
    end

    // running sum never passes the chunk size while streaming data
    a_used_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (used_reg <= {1'b0, len_reg}))
        else $error("frame sum beyond data chunk");

    // a finished file without end of file always parks in drain
    a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done && !end_of_file) |=> (phase_reg == PH_DRAIN))
        else $error("done without drain");

    // data phase only entered with a parsed fmt chunk
    a_data_needs_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> fmt_seen_reg)
        else $error("data phase without fmt");

endmodule

`default_nettype wire

// File: rtl/wav_stream_to_i2s_frames.sv
`default_nettype none

// channel    dir  fields                                                        notes
// byte_in    in   file_byte[7:0], end_of_file                                   one file byte per word
// frame_out  out  frame_valid, left_sample, right_sample, done_res, status,     zero or one word
//                 sample_rate                                                   per input byte
//
// one byte is taken per cycle while byte_in is not stalled; its result word is registered
// and shows on frame_out the cycle after the byte is accepted
// the parse and frame assembly settle in one pass of logic between the byte and the
// state and result registers, so there is no per-byte latency beyond that register
// rst_n clears the parser to the start of a file and empties the result register
// byte_in stalls only while a result word is held and frame_out is not ready

module wav_stream_to_i2s_frames
    import ws2i_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ws2i_byte_if.sink     byte_in,
    ws2i_frame_if.source  frame_out
);

    logic    accept;
    logic    emit;
    result_t core_result;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // a byte may enter whenever the result register is empty or being drained
    assign byte_in.ready = !out_valid_reg || frame_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    ws2i_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .file_byte   (byte_in.file_byte),
        .end_of_file (byte_in.end_of_file),
        .result      (core_result),
        .emit        (emit)
    );

    always_comb
    begin
        if (accept)
            out_valid_next = emit;
        else if (frame_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload only loads when a new word is produced
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= core_result;
    end

    assign frame_out.valid        = out_valid_reg;
    assign frame_out.frame_valid  = out_reg.frame_valid;
    assign frame_out.left_sample  = out_reg.left_sample;
    assign frame_out.right_sample = out_reg.right_sample;
    assign frame_out.done_res     = out_reg.done_res;
    assign frame_out.status       = out_reg.status;
    assign frame_out.sample_rate  = out_reg.sample_rate;

    // every word carries a frame, a final status, or both
    a_word_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        frame_out.valid |-> (frame_out.frame_valid || frame_out.done_res))
        else $error("empty result word");

    // status and rate are quiet on frame-only words
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_out.valid && !frame_out.done_res) |->
            (frame_out.status == ST_OK && frame_out.sample_rate == 32'd0))
        else $error("status without done");

    // an accepted byte that makes a word shows it in the next cycle
    a_word_follows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> frame_out.valid)
        else $error("result word lost");

endmodule

`default_nettype wire
